/* rtl/cbm_pkg.sv */
package cbm_pkg;

   // item modes
   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_LOAD  = 2'd2;

   // configuration register indexes
   localparam logic CSR_ROM_BYTES = 1'b0;
   localparam logic CSR_RAM_BYTES = 1'b1;

   localparam int CSR_DATA_W = 18;

   // bus map
   localparam logic [15:0] ADDR_ROM_BANK_SEL = 16'h2000;
   localparam logic [15:0] ADDR_SWITCH_ROM   = 16'h4000;
   localparam logic [15:0] ADDR_MODE_SEL     = 16'h6000;
   localparam logic [15:0] ADDR_ROM_END      = 16'h8000;
   localparam logic [15:0] ADDR_RAM_BASE     = 16'hA000;
   localparam logic [15:0] ADDR_RAM_END      = 16'hC000;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
   localparam logic [7:0] OPEN_BUS_BYTE  = 8'hFF;

   localparam int ROM_BANK_BYTES = 16384;
   localparam int RAM_BANK_BYTES = 8192;

   localparam logic [17:0] ROM_BYTES_RESET = 18'd131072;
   localparam logic [15:0] RAM_BYTES_RESET = 16'd0;

   // widest store indexes over the parameter range
   localparam int ROM_ADDR_MAX_W = 21;
   localparam int RAM_ADDR_MAX_W = 15;

   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_ROM  = 2'd1,
      SRC_RAM  = 2'd2
   } src_type;

   typedef struct packed {
      logic                      rom_we;
      logic                      rom_re;
      logic [ROM_ADDR_MAX_W-1:0] rom_addr;
      logic                      ram_we;
      logic                      ram_re;
      logic [RAM_ADDR_MAX_W-1:0] ram_addr;
      logic [7:0]                wdata;
   } mem_req_type;

endpackage

/* rtl/cartridge_bank_mapper.sv */
// Bank-switching cartridge controller: one access per item (bus read, bus write
// or ROM image load byte), one read_data byte per item, 0xFF for anything but a
// mapped read. Items are taken back to back at one per cycle while req_stall is
// low; the synchronous ROM or RAM read happens at the transfer edge and the
// result register loads from it once the output is free, driving rsp_read_data.
// After reset all RAM_BANKS*8192 bytes of external RAM are swept to zero at one
// byte a cycle, during which req_stall stays high; configuration writes are
// taken throughout.
module cartridge_bank_mapper #(
   parameter int ROM_BANKS = 8,
   parameter int RAM_BANKS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [16:0] req_load_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0] csr_write_data
);

   logic                 accept;
   logic                 clearing;
   cbm_pkg::mem_req_type mem_req;
   cbm_pkg::src_type     src;
   logic [7:0]           rom_rdata;
   logic [7:0]           ram_rdata;

   logic [17:0] rom_bytes_ff;
   logic [15:0] ram_bytes_ff;

   logic             s1_valid_ff, s1_valid_in;
   cbm_pkg::src_type s1_src_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             out_free;
   logic             s1_move;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bytes_ff <= cbm_pkg::ROM_BYTES_RESET;
         ram_bytes_ff <= cbm_pkg::RAM_BYTES_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cbm_pkg::CSR_ROM_BYTES: rom_bytes_ff <= csr_write_data;
            cbm_pkg::CSR_RAM_BYTES: ram_bytes_ff <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign s1_move   = s1_valid_ff & out_free;
   assign req_stall = clearing | (s1_valid_ff & ~out_free);
   assign accept    = req_valid & ~req_stall;

   cbm_xlate #(
      .ROM_BANKS (ROM_BANKS),
      .RAM_BANKS (RAM_BANKS)
   ) u_xlate (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .mode         (req_mode),
      .address      (req_address),
      .write_data   (req_write_data),
      .load_address (req_load_address),
      .rom_bytes    (rom_bytes_ff),
      .ram_bytes    (ram_bytes_ff),
      .mem_req      (mem_req),
      .src          (src)
   );

   cbm_store #(
      .ROM_BANKS (ROM_BANKS),
      .RAM_BANKS (RAM_BANKS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .mem_req   (mem_req),
      .rom_rdata (rom_rdata),
      .ram_rdata (ram_rdata),
      .clearing  (clearing)
   );

   assign s1_valid_in  = accept | (s1_valid_ff & ~s1_move);
   assign rsp_valid_in = s1_move | (rsp_valid_ff & rsp_stall);

   // pick the memory that served the access, open bus otherwise
   always_comb begin
      case (s1_src_ff)
         cbm_pkg::SRC_ROM: rsp_data_in = rom_rdata;
         cbm_pkg::SRC_RAM: rsp_data_in = ram_rdata;
         default:          rsp_data_in = cbm_pkg::OPEN_BUS_BYTE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_src_ff <= src;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> clearing)
      else $error("RAM sweep not started after reset");

   a_idle_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !s1_valid_ff && !accept)
      else $error("access in flight during RAM sweep");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_src_ff))
      else $error("memory stage lost while output stalled");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mem_req.rom_we, mem_req.rom_re, mem_req.ram_we, mem_req.ram_re}))
      else $error("more than one memory access for one item");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item missing from memory stage");

endmodule

/* rtl/cbm_xlate.sv */
module cbm_xlate #(
   parameter int ROM_BANKS = 8,
   parameter int RAM_BANKS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           mode,
   input  logic [15:0]          address,
   input  logic [7:0]           write_data,
   input  logic [16:0]          load_address,
   input  logic [17:0]          rom_bytes,
   input  logic [15:0]          ram_bytes,
   output cbm_pkg::mem_req_type mem_req,
   output cbm_pkg::src_type     src
);

   localparam logic [21:0] ROM_DEPTH = 22'(ROM_BANKS * cbm_pkg::ROM_BANK_BYTES);
   localparam logic [15:0] RAM_DEPTH = 16'(RAM_BANKS * cbm_pkg::RAM_BANK_BYTES);

   logic [6:0] rom_bank_ff, rom_bank_in;
   logic [1:0] ram_bank_ff, ram_bank_in;
   logic       ram_en_ff, ram_en_in;
   logic       bank_mode_ff, bank_mode_in;

   logic [21:0] rom_off;
   logic [14:0] ram_off;
   logic        rom_in_range;
   logic        ram_ok;
   logic        load_in_range;

   assign rom_off = {1'b0, rom_bank_ff, address[13:0]};
   assign ram_off = {ram_bank_ff, address[12:0]};
   assign rom_in_range = (rom_off < {4'b0, rom_bytes}) && (rom_off < ROM_DEPTH);
   assign load_in_range = {5'b0, load_address} < ROM_DEPTH;
   assign ram_ok = ram_en_ff
      && (address >= cbm_pkg::ADDR_RAM_BASE) && (address < cbm_pkg::ADDR_RAM_END)
      && ({1'b0, ram_off} < ram_bytes) && ({1'b0, ram_off} < RAM_DEPTH);

   always_comb begin
      mem_req       = '0;
      mem_req.wdata = write_data;
      src           = cbm_pkg::SRC_NONE;
      rom_bank_in   = rom_bank_ff;
      ram_bank_in   = ram_bank_ff;
      ram_en_in     = ram_en_ff;
      bank_mode_in  = bank_mode_ff;
      case (mode)
         cbm_pkg::MODE_READ: begin
            if (address < cbm_pkg::ADDR_SWITCH_ROM) begin
               mem_req.rom_re   = accept;
               mem_req.rom_addr = {7'b0, address[13:0]};
               src              = cbm_pkg::SRC_ROM;
            end else if (address < cbm_pkg::ADDR_ROM_END) begin
               if (rom_in_range) begin
                  mem_req.rom_re   = accept;
                  mem_req.rom_addr = rom_off[20:0];
                  src              = cbm_pkg::SRC_ROM;
               end
            end else if (ram_ok) begin
               mem_req.ram_re   = accept;
               mem_req.ram_addr = ram_off;
               src              = cbm_pkg::SRC_RAM;
            end
         end
         cbm_pkg::MODE_WRITE: begin
            if (address < cbm_pkg::ADDR_ROM_BANK_SEL) begin
               ram_en_in = write_data[3:0] == cbm_pkg::RAM_ENABLE_KEY;
            end else if (address < cbm_pkg::ADDR_SWITCH_ROM) begin
               // bank-zero rule: a zero low field selects bank one
               rom_bank_in[4:0] = (write_data[4:0] == 5'd0) ? 5'd1 : write_data[4:0];
            end else if (address < cbm_pkg::ADDR_MODE_SEL) begin
               if (bank_mode_ff) begin
                  ram_bank_in = write_data[1:0];
               end else begin
                  rom_bank_in[6:5] = write_data[1:0];
               end
            end else if (address < cbm_pkg::ADDR_ROM_END) begin
               bank_mode_in = write_data[0];
            end else if (ram_ok) begin
               mem_req.ram_we   = accept;
               mem_req.ram_addr = ram_off;
            end
         end
         cbm_pkg::MODE_LOAD: begin
            if (load_in_range) begin
               mem_req.rom_we   = accept;
               mem_req.rom_addr = {4'b0, load_address};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_ff  <= 7'd1;
         ram_bank_ff  <= 2'd0;
         ram_en_ff    <= 1'b0;
         bank_mode_ff <= 1'b0;
      end else if (accept) begin
         rom_bank_ff  <= rom_bank_in;
         ram_bank_ff  <= ram_bank_in;
         ram_en_ff    <= ram_en_in;
         bank_mode_ff <= bank_mode_in;
      end
   end

endmodule

/* rtl/cbm_store.sv */
module cbm_store #(
   parameter int ROM_BANKS = 8,
   parameter int RAM_BANKS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cbm_pkg::mem_req_type mem_req,
   output logic [7:0]           rom_rdata,
   output logic [7:0]           ram_rdata,
   output logic                 clearing
);

   localparam int ROM_DEPTH = ROM_BANKS * cbm_pkg::ROM_BANK_BYTES;
   localparam int RAM_DEPTH = RAM_BANKS * cbm_pkg::RAM_BANK_BYTES;
   localparam int ROM_AW    = $clog2(ROM_DEPTH);
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   logic [7:0] rom_mem [0:ROM_DEPTH-1];
   logic [7:0] ram_mem [0:RAM_DEPTH-1];

   logic [7:0] rom_rdata_ff;
   logic [7:0] ram_rdata_ff;

   logic              clr_busy_ff, clr_busy_in;
   logic [RAM_AW-1:0] clr_cnt_ff, clr_cnt_in;

   logic              ram_we;
   logic [RAM_AW-1:0] ram_waddr;
   logic [7:0]        ram_wdata;

   // sweep zeros through external RAM after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == RAM_AW'(RAM_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   assign ram_we    = clr_busy_ff | mem_req.ram_we;
   assign ram_waddr = clr_busy_ff ? clr_cnt_ff : mem_req.ram_addr[RAM_AW-1:0];
   assign ram_wdata = clr_busy_ff ? 8'h00 : mem_req.wdata;

   always_ff @(posedge clock) begin
      if (mem_req.rom_we) begin
         rom_mem[mem_req.rom_addr[ROM_AW-1:0]] <= mem_req.wdata;
      end
      if (mem_req.rom_re) begin
         rom_rdata_ff <= rom_mem[mem_req.rom_addr[ROM_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         ram_mem[ram_waddr] <= ram_wdata;
      end
      if (mem_req.ram_re) begin
         ram_rdata_ff <= ram_mem[mem_req.ram_addr[RAM_AW-1:0]];
      end
   end

   assign rom_rdata = rom_rdata_ff;
   assign ram_rdata = ram_rdata_ff;
   assign clearing  = clr_busy_ff;

endmodule

/* tb/cartridge_bank_mapper_tb.sv */
module cartridge_bank_mapper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROM_BANKS     = 8;
   localparam int RAM_BANKS     = 4;
   localparam int ROM_DEPTH     = ROM_BANKS * cbm_pkg::ROM_BANK_BYTES;
   localparam int RAM_DEPTH     = RAM_BANKS * cbm_pkg::RAM_BANK_BYTES;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 200;
   localparam int PRINT_CAP     = 100;

   // mode 3 has no name in the package; the block must treat it as a no-op
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef enum logic {STEP_ACCESS, STEP_SIZES} step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      logic [1:0]    mode;
      logic [15:0]   addr;
      logic [7:0]    data;
      logic [16:0]   load;
      logic          typed;
      logic [7:0]    due;
      logic [17:0]   rom_cfg;
      logic [15:0]   ram_cfg;
   } plan_row_type;

   localparam int PLAN_ROWS = 29;
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{STEP_ACCESS, MODE_SPARE,          16'hFFFF, 8'hFF, 17'h1FFFF, 1'b1, 8'hFF, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_LOAD,  16'h0000, 8'h5A, 17'h00000, 1'b1, 8'hFF, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_LOAD,  16'h0000, 8'hA5, 17'h1FFFF, 1'b1, 8'hFF, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_LOAD,  16'h0000, 8'h3C, 17'h04000, 1'b1, 8'hFF, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_LOAD,  16'h0000, 8'h81, 17'h03FFF, 1'b1, 8'hFF, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_READ,  16'h0000, 8'h00, 17'h00000, 1'b1, 8'h5A, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_READ,  16'h3FFF, 8'h00, 17'h00000, 1'b1, 8'h81, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_READ,  16'h4000, 8'h00, 17'h00000, 1'b1, 8'h3C, 18'd0, 16'd0},
      // bank number zero is promoted to one
      '{STEP_ACCESS, cbm_pkg::MODE_WRITE, 16'h2000, 8'h00, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_READ,  16'h4000, 8'h00, 17'h00000, 1'b1, 8'h3C, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_WRITE, 16'h3FFF, 8'hE7, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_READ,  16'h7FFF, 8'h00, 17'h00000, 1'b1, 8'hA5, 18'd0, 16'd0},
      // upper bank bits push the window past the end of the store
      '{STEP_ACCESS, cbm_pkg::MODE_WRITE, 16'h4000, 8'h03, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_READ,  16'h4000, 8'h00, 17'h00000, 1'b1, 8'hFF, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_WRITE, 16'h6000, 8'h01, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_WRITE, 16'h5FFF, 8'hFE, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_WRITE, 16'h0000, 8'h0A, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0},
      // enabled but no RAM fitted
      '{STEP_ACCESS, cbm_pkg::MODE_WRITE, 16'hA000, 8'h77, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_READ,  16'hA000, 8'h00, 17'h00000, 1'b1, 8'hFF, 18'd0, 16'd0},
      '{STEP_SIZES,  cbm_pkg::MODE_READ,  16'h0000, 8'h00, 17'h00000, 1'b0, 8'h00,
        18'd32768, 16'd32768},
      '{STEP_ACCESS, cbm_pkg::MODE_WRITE, 16'hBFFF, 8'h99, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_READ,  16'hBFFF, 8'h00, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0},
      // shrink RAM to one byte short of the end of bank 2 so its last byte falls outside
      '{STEP_SIZES,  cbm_pkg::MODE_READ,  16'h0000, 8'h00, 17'h00000, 1'b0, 8'h00,
        18'd32768, 16'h5FFF},
      '{STEP_ACCESS, cbm_pkg::MODE_READ,  16'hBFFF, 8'h00, 17'h00000, 1'b1, 8'hFF, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_READ,  16'hBFFE, 8'h00, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_WRITE, 16'h7FFF, 8'hFE, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_WRITE, 16'h4000, 8'h00, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_WRITE, 16'h2000, 8'h21, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0},
      '{STEP_ACCESS, cbm_pkg::MODE_READ,  16'h4000, 8'h00, 17'h00000, 1'b0, 8'h00, 18'd0, 16'd0}
   };

   logic                           clock;
   logic                           reset            = 1'b1;
   logic                           req_valid        = 1'b0;
   logic                           req_stall;
   logic [1:0]                     req_mode         = cbm_pkg::MODE_READ;
   logic [15:0]                    req_address      = '0;
   logic [7:0]                     req_write_data   = '0;
   logic [16:0]                    req_load_address = '0;
   logic                           rsp_valid;
   logic                           rsp_stall        = 1'b0;
   logic [7:0]                     rsp_read_data;
   logic                           csr_valid        = 1'b0;
   logic                           csr_ready;
   logic                           csr_index        = cbm_pkg::CSR_ROM_BYTES;
   logic [cbm_pkg::CSR_DATA_W-1:0] csr_write_data   = '0;

   // mapper state as the bus sees it
   logic [7:0]  rom_image [ROM_DEPTH];
   bit          rom_loaded [ROM_DEPTH];
   logic [7:0]  ram_image [RAM_DEPTH];
   logic [6:0]  rom_bank;
   logic [1:0]  ram_bank;
   logic        ram_on;
   logic        bank_mode;
   logic [17:0] rom_size;
   logic [15:0] ram_size;

   logic [7:0]  read_data_due [$];

   int gap_pct         = 0;
   int stall_pct       = 0;
   int errors          = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int loaded_bytes    = 0;
   int settings        = 0;
   int cycle_count     = 0;

   cartridge_bank_mapper #(
      .ROM_BANKS(ROM_BANKS),
      .RAM_BANKS(RAM_BANKS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_load_address(req_load_address),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // physical ROM byte behind a bus address, or -1 when not backed by the store
   function automatic int rom_index(logic [15:0] addr);
      int unsigned offset;
      if (addr < cbm_pkg::ADDR_SWITCH_ROM) return int'(addr);
      if (addr >= cbm_pkg::ADDR_ROM_END) return -1;
      offset = rom_bank * cbm_pkg::ROM_BANK_BYTES + (addr - cbm_pkg::ADDR_SWITCH_ROM);
      if (offset < rom_size && offset < ROM_DEPTH) return int'(offset);
      return -1;
   endfunction

   function automatic int ram_index(logic [15:0] addr);
      int unsigned offset;
      if (!ram_on || ram_size == 0) return -1;
      if (addr < cbm_pkg::ADDR_RAM_BASE || addr >= cbm_pkg::ADDR_RAM_END) return -1;
      offset = ram_bank * cbm_pkg::RAM_BANK_BYTES + (addr - cbm_pkg::ADDR_RAM_BASE);
      if (offset >= ram_size || offset >= RAM_DEPTH) return -1;
      return int'(offset);
   endfunction

   function automatic logic [7:0] apply_access(logic [1:0] mode, logic [15:0] addr,
                                               logic [7:0] data, logic [16:0] load);
      int         slot;
      logic [7:0] result;
      result = cbm_pkg::OPEN_BUS_BYTE;
      if (mode == cbm_pkg::MODE_READ) begin
         slot = rom_index(addr);
         if (slot >= 0) begin
            result = rom_image[slot];
         end else begin
            slot = ram_index(addr);
            if (slot >= 0) result = ram_image[slot];
         end
      end else if (mode == cbm_pkg::MODE_WRITE) begin
         if (addr < cbm_pkg::ADDR_ROM_BANK_SEL) begin
            ram_on = (data[3:0] == cbm_pkg::RAM_ENABLE_KEY);
         end else if (addr < cbm_pkg::ADDR_SWITCH_ROM) begin
            rom_bank[4:0] = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
         end else if (addr < cbm_pkg::ADDR_MODE_SEL) begin
            if (!bank_mode) rom_bank[6:5] = data[1:0];
            else ram_bank = data[1:0];
         end else if (addr < cbm_pkg::ADDR_ROM_END) begin
            bank_mode = data[0];
         end else begin
            slot = ram_index(addr);
            if (slot >= 0) ram_image[slot] = data;
         end
      end else if (mode == cbm_pkg::MODE_LOAD && load < ROM_DEPTH) begin
         if (!rom_loaded[load]) loaded_bytes++;
         rom_image[load]  = data;
         rom_loaded[load] = 1'b1;
      end
      return result;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] due, logic [7:0] got);
      errors++;
      if (errors <= PRINT_CAP)
         $display("%0t: %s: expected %02h, got %02h", $time, what, due, got);
   endtask

   // one transfer on the request channel; pinned is used in place of the prediction when typed is set
   task automatic drive_access(logic [1:0] mode, logic [15:0] addr, logic [7:0] data,
                               logic [16:0] load, logic typed, logic [7:0] pinned);
      logic [7:0] predicted;
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_address      <= addr;
      req_write_data   <= data;
      req_load_address <= load;
      do @(posedge clock); while (req_stall);
      predicted = apply_access(mode, addr, data, load);
      read_data_due.push_back(typed ? pinned : predicted);
      items_sent++;
   endtask

   // hold the sender until every result is back, then let the pipe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (read_data_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_sizes(logic [17:0] rom_cfg, logic [15:0] ram_cfg);
      csr_valid      <= 1'b1;
      csr_index      <= cbm_pkg::CSR_ROM_BYTES;
      csr_write_data <= rom_cfg;
      do @(posedge clock); while (!csr_ready);
      rom_size = rom_cfg;
      csr_index      <= cbm_pkg::CSR_RAM_BYTES;
      csr_write_data <= cbm_pkg::CSR_DATA_W'(ram_cfg);
      do @(posedge clock); while (!csr_ready);
      ram_size = ram_cfg;
      csr_valid <= 1'b0;
      settings++;
   endtask

   always @(posedge clock) begin : result_check
      logic [7:0] due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (read_data_due.size() == 0) begin
            report_mismatch("read_data with no transfer pending", 8'hxx, rsp_read_data);
         end else begin
            due = read_data_due.pop_front();
            results_checked++;
            if (rsp_read_data !== due) report_mismatch("read_data", due, rsp_read_data);
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("cycle limit hit with %0d results outstanding", read_data_due.size());
         $display("cartridge_bank_mapper_tb failed");
         $finish;
      end
   end

   initial begin : stimulus
      int          n;
      int          phase;
      int          pick;
      int          idx;
      logic [1:0]  mode;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [16:0] load;
      logic [17:0] rom_cfg;
      logic [15:0] ram_cfg;

      for (n = 0; n < ROM_DEPTH; n++) rom_loaded[n] = 1'b0;
      for (n = 0; n < RAM_DEPTH; n++) ram_image[n] = 8'h00;
      rom_bank  = 7'd1;
      ram_bank  = 2'd0;
      ram_on    = 1'b0;
      bank_mode = 1'b0;
      rom_size  = cbm_pkg::ROM_BYTES_RESET;
      ram_size  = cbm_pkg::RAM_BYTES_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < PLAN_ROWS; n++) begin
         if (DIRECTED_PLAN[n].kind == STEP_SIZES) begin
            wait_idle();
            program_sizes(DIRECTED_PLAN[n].rom_cfg, DIRECTED_PLAN[n].ram_cfg);
         end else begin
            drive_access(DIRECTED_PLAN[n].mode, DIRECTED_PLAN[n].addr,
                         DIRECTED_PLAN[n].data, DIRECTED_PLAN[n].load,
                         DIRECTED_PLAN[n].typed, DIRECTED_PLAN[n].due);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase % 4)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct   = 78;
               stall_pct = 0;
            end
            2: begin
               gap_pct   = 0;
               stall_pct = 78;
            end
            default: begin
               gap_pct   = 12;
               stall_pct = 12;
            end
         endcase
         case (phase)
            0: begin
               rom_cfg = 18'd131072;
               ram_cfg = 16'd32768;
            end
            1: begin
               rom_cfg = 18'd32768;
               ram_cfg = 16'd8192;
            end
            2: begin
               rom_cfg = 18'd70001;
               ram_cfg = 16'd0;
            end
            3: begin
               rom_cfg = 18'd131072;
               ram_cfg = 16'd1;
            end
            4: begin
               rom_cfg = 18'd49152;
               ram_cfg = 16'd24577;
            end
            5: begin
               rom_cfg = 18'd32768;
               ram_cfg = 16'd32768;
            end
            default: begin
               rom_cfg = 18'($urandom_range(131072, 32768));
               ram_cfg = 16'($urandom_range(32768, 0));
            end
         endcase
         program_sizes(rom_cfg, ram_cfg);

         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            mode = cbm_pkg::MODE_READ;
            addr = 16'($urandom);
            data = 8'($urandom);
            load = 17'($urandom);
            if (pick < 25) begin
               // control register writes, biased towards useful values
               mode     = cbm_pkg::MODE_WRITE;
               addr[15] = 1'b0;
               case (addr[14:13])
                  2'd0: begin
                     if ($urandom_range(1) != 0) data[3:0] = cbm_pkg::RAM_ENABLE_KEY;
                  end
                  2'd1: begin
                     if ($urandom_range(1) != 0) data[4:3] = 2'b00;
                  end
                  2'd2: begin
                     if ($urandom_range(2) != 0) data[1:0] = 2'b00;
                  end
                  default: ;
               endcase
            end else if (pick < 55) begin
               // ROM reads, half of them close to a bank boundary
               addr[15] = 1'b0;
               if ($urandom_range(1) != 0)
                  addr[13:4] = ($urandom_range(1) != 0) ? 10'h3FF : 10'h000;
            end else if (pick < 75) begin
               addr[15:13] = 3'b101;
               mode = ($urandom_range(1) != 0) ? cbm_pkg::MODE_WRITE : cbm_pkg::MODE_READ;
            end else if (pick < 85) begin
               mode = cbm_pkg::MODE_LOAD;
            end else begin
               mode = 2'($urandom_range(3));
            end
            // load any ROM byte the read would reach before it has been written
            idx = rom_index(addr);
            if (mode == cbm_pkg::MODE_READ && idx >= 0 && !rom_loaded[idx])
               drive_access(cbm_pkg::MODE_LOAD, addr, 8'($urandom), 17'(idx), 1'b0, 8'h00);
            drive_access(mode, addr, data, load, 1'b0, 8'h00);
            if ($urandom_range(299) == 0) wait_idle();
         end
      end

      wait_idle();
      $display("run covered %0d transfers, %0d results checked, %0d size settings,",
               items_sent, results_checked, settings);
      $display("%0d distinct ROM bytes loaded, %0d mismatches", loaded_bytes, errors);
      if (errors == 0) begin
         $display("cartridge_bank_mapper_tb passed");
      end else begin
         $display("cartridge_bank_mapper_tb failed");
      end
      $finish;
   end

endmodule
